@@ hw/rtl/camera_basis_from_angles_defines.svh @@
// assertion helpers shared by the rtl
`ifndef CAMERA_BASIS_FROM_ANGLES_DEFINES_SVH
`define CAMERA_BASIS_FROM_ANGLES_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBFA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("camera basis check failed");

// next-cycle implication, sampled on clk, off during reset
`define CBFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("camera basis check failed");

`endif

@@ hw/rtl/cbfa_pkg.sv @@
`default_nettype none
package cbfa_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int Q          = 30;

    localparam logic [31:0] AMASK   = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int          QUARTER = 1 << (ANGLE_BITS - 2);

    localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;
    localparam logic [30:0] ONE_Q  = 31'h4000_0000;

    localparam int SIN_STEPS = 4;
    localparam int COS_STEPS = 5;
    localparam logic [6:0] SIN_DIV [SIN_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0] COS_DIV [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    // ceil(2^32 / d), one correction step fixes the quotient
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'((64'h1_0000_0000 + 64'd71) / 64'd72),
        32'((64'h1_0000_0000 + 64'd41) / 64'd42),
        32'((64'h1_0000_0000 + 64'd19) / 64'd20),
        32'((64'h1_0000_0000 + 64'd5) / 64'd6)};
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'((64'h1_0000_0000 + 64'd89) / 64'd90),
        32'((64'h1_0000_0000 + 64'd55) / 64'd56),
        32'((64'h1_0000_0000 + 64'd29) / 64'd30),
        32'((64'h1_0000_0000 + 64'd11) / 64'd12),
        32'((64'h1_0000_0000 + 64'd1) / 64'd2)};

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int NORM_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int TRIG_LAT   = 3 + 3 * COS_STEPS + 1;
    localparam int XPROD_LAT  = 2;
    localparam int DLY        = XPROD_LAT + NORM_LAT;
    localparam int PIPE_LAT   = TRIG_LAT + 2 + 2 * DLY;

    localparam int          EMIT_SHIFT = Q - FRAC_BITS;
    localparam logic [32:0] EMIT_HALF  = (33'd1 << EMIT_SHIFT) >> 1;

    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    typedef logic [2:0][31:0] vec3_t;
    typedef logic [2:0][63:0] wide3_t;

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic [30:0] h;
        logic [1:0]  quad;
        logic        swap;
    } trig_lane_t;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] probe;
    } sqrt_state_t;

    typedef struct packed {
        logic [2:0][29:0] mag;
        logic [2:0]       neg;
        logic             nz;
    } norm_side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       nz;
    } sign_side_t;

    typedef struct packed {
        logic [2:0][30:0] rem;
        logic [2:0][30:0] low;
        logic [2:0][30:0] quo;
    } div_state_t;

    // q60 product to q30, half away from zero
    function automatic logic [31:0] round_q30(input logic [63:0] p);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = p[63] ? (64'd0 - p) : p;
        rnd = (mag + (64'd1 << (Q - 1))) >> Q;
        round_q30 = p[63] ? 32'(64'd0 - rnd) : rnd[31:0];
    endfunction

    // q30 to output format, half away from zero, saturated
    function automatic logic [15:0] emit_q(input logic [31:0] v);
        logic [32:0] mag;
        logic [32:0] rnd;
        mag = {1'b0, v[31] ? (32'd0 - v) : v};
        rnd = (mag + EMIT_HALF) >> EMIT_SHIFT;
        if (v[31])
        begin
            emit_q = (rnd > 33'd32768) ? 16'h8000 : 16'(33'd0 - rnd);
        end
        else
        begin
            emit_q = (rnd > 33'd32767) ? 16'h7FFF : rnd[15:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cbfa_horner_cell.sv @@
`default_nettype none
module cbfa_horner_cell
    import cbfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [6:0] div,
    input  wire logic [31:0] recip,
    input  wire trig_lane_t lane_in,
    output trig_lane_t      lane_out
);

    trig_lane_t  lane1_reg;
    trig_lane_t  lane2_reg;
    trig_lane_t  lane3_reg;
    logic [29:0] prod_reg;
    logic [29:0] prod2_reg;
    logic [29:0] quot_reg;
    logic [60:0] prod_full;
    logic [61:0] recip_full;
    logic [36:0] check;
    logic [29:0] quot_fix;
    trig_lane_t  lane3_next;

    always_comb
    begin
        prod_full  = lane_in.x2 * lane_in.h;
        recip_full = prod_reg * recip;
        check      = quot_reg * div;
        // estimate is exact or one too high
        quot_fix   = (check > 37'(prod2_reg)) ? (quot_reg - 30'd1) : quot_reg;
        lane3_next   = lane2_reg;
        lane3_next.h = ONE_Q - {1'b0, quot_fix};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane1_reg <= lane_in;
            prod_reg  <= prod_full[59:30];
            lane2_reg <= lane1_reg;
            prod2_reg <= prod_reg;
            quot_reg  <= recip_full[61:32];
            lane3_reg <= lane3_next;
        end
    end

    assign lane_out = lane3_reg;

endmodule
`default_nettype wire

@@ hw/rtl/cbfa_trig.sv @@
`default_nettype none
module cbfa_trig
    import cbfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] angle,
    output logic [31:0]      sn,
    output logic [31:0]      cs
);

    logic [29:0] r_reg;
    logic [1:0]  quad0_reg;
    logic        swap0_reg;
    logic [29:0] x_reg;
    logic [1:0]  quad1_reg;
    logic        swap1_reg;
    trig_lane_t  lane0_reg;
    logic [29:0] s_reg;
    logic [29:0] s_d1_reg;
    logic [29:0] s_d2_reg;
    logic [31:0] sn_reg;
    logic [31:0] cs_reg;

    trig_lane_t  sin_lane [SIN_STEPS+1];
    trig_lane_t  cos_lane [COS_STEPS+1];

    logic        swap_in;
    logic [29:0] r_in;
    logic [61:0] x_full;
    logic [59:0] x2_full;
    logic [60:0] s_full;
    logic [31:0] a_val;
    logic [31:0] b_val;
    logic [31:0] sn_next;
    logic [31:0] cs_next;
    trig_lane_t  cos_end;

    always_comb
    begin
        swap_in = angle[29:0] > 30'h2000_0000;
        r_in    = swap_in ? 30'(31'h4000_0000 - {1'b0, angle[29:0]}) : angle[29:0];
        x_full  = r_reg * PI_Q30;
        x2_full = x_reg * x_reg;
        s_full  = sin_lane[SIN_STEPS].x * sin_lane[SIN_STEPS].h;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg          <= r_in;
            quad0_reg      <= angle[31:30];
            swap0_reg      <= swap_in;
            x_reg          <= x_full[60:31];
            quad1_reg      <= quad0_reg;
            swap1_reg      <= swap0_reg;
            lane0_reg.x    <= x_reg;
            lane0_reg.x2   <= x2_full[59:30];
            lane0_reg.h    <= ONE_Q;
            lane0_reg.quad <= quad1_reg;
            lane0_reg.swap <= swap1_reg;
            s_reg          <= s_full[59:30];
            s_d1_reg       <= s_reg;
            s_d2_reg       <= s_d1_reg;
            sn_reg         <= sn_next;
            cs_reg         <= cs_next;
        end
    end

    assign sin_lane[0] = lane0_reg;
    assign cos_lane[0] = lane0_reg;

    for (genvar g = 0; g < SIN_STEPS; g++)
    begin : g_sin
        cbfa_horner_cell u_cell (
            .clk      (clk),
            .en       (en),
            .div      (SIN_DIV[g]),
            .recip    (SIN_RECIP[g]),
            .lane_in  (sin_lane[g]),
            .lane_out (sin_lane[g+1])
        );
    end

    for (genvar g = 0; g < COS_STEPS; g++)
    begin : g_cos
        cbfa_horner_cell u_cell (
            .clk      (clk),
            .en       (en),
            .div      (COS_DIV[g]),
            .recip    (COS_RECIP[g]),
            .lane_in  (cos_lane[g]),
            .lane_out (cos_lane[g+1])
        );
    end

    assign cos_end = cos_lane[COS_STEPS];

    // octant fold back to the full circle
    always_comb
    begin
        a_val = cos_end.swap ? 32'(cos_end.h) : 32'(s_d2_reg);
        b_val = cos_end.swap ? 32'(s_d2_reg) : 32'(cos_end.h);
        case (cos_end.quad)
            2'd0:
            begin
                sn_next = a_val;
                cs_next = b_val;
            end
            2'd1:
            begin
                sn_next = b_val;
                cs_next = 32'd0 - a_val;
            end
            2'd2:
            begin
                sn_next = 32'd0 - a_val;
                cs_next = 32'd0 - b_val;
            end
            default:
            begin
                sn_next = 32'd0 - b_val;
                cs_next = a_val;
            end
        endcase
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule
`default_nettype wire

@@ hw/rtl/cbfa_sqrt_cell.sv @@
`default_nettype none
module cbfa_sqrt_cell
    import cbfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire sqrt_state_t st_in,
    input  wire norm_side_t  side_in,
    output sqrt_state_t      st_out,
    output norm_side_t       side_out
);

    sqrt_state_t st_reg;
    norm_side_t  side_reg;
    sqrt_state_t st_next;
    logic [63:0] trial;

    always_comb
    begin
        trial         = st_in.res + st_in.probe;
        st_next.probe = st_in.probe >> 2;
        if (st_in.num >= trial)
        begin
            st_next.num = st_in.num - trial;
            st_next.res = (st_in.res >> 1) + st_in.probe;
        end
        else
        begin
            st_next.num = st_in.num;
            st_next.res = st_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg   <= st_next;
            side_reg <= side_in;
        end
    end

    assign st_out   = st_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

@@ hw/rtl/cbfa_div_cell.sv @@
`default_nettype none
module cbfa_div_cell
    import cbfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] n_in,
    input  wire sign_side_t  side_in,
    input  wire div_state_t  st_in,
    output logic [30:0]      n_out,
    output sign_side_t       side_out,
    output div_state_t       st_out
);

    logic [30:0] n_reg;
    sign_side_t  side_reg;
    div_state_t  st_reg;
    div_state_t  st_next;
    logic [31:0] r2;

    // one restoring step per lane
    always_comb
    begin
        st_next = st_in;
        r2      = '0;
        for (int i = 0; i < 3; i++)
        begin
            r2 = {st_in.rem[i], st_in.low[i][30]};
            st_next.low[i] = {st_in.low[i][29:0], 1'b0};
            if (r2 >= {1'b0, n_in})
            begin
                st_next.rem[i] = 31'(r2 - {1'b0, n_in});
                st_next.quo[i] = {st_in.quo[i][29:0], 1'b1};
            end
            else
            begin
                st_next.rem[i] = r2[30:0];
                st_next.quo[i] = {st_in.quo[i][29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_in;
            side_reg <= side_in;
            st_reg   <= st_next;
        end
    end

    assign n_out    = n_reg;
    assign side_out = side_reg;
    assign st_out   = st_reg;

endmodule
`default_nettype wire

@@ hw/rtl/cbfa_norm.sv @@
`default_nettype none
module cbfa_norm
    import cbfa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire wide3_t v,
    output vec3_t       o,
    output logic        nz
);

    wide3_t      mag_a_reg;
    logic [2:0]  neg_a_reg;
    wide3_t      mag_b_reg;
    logic [2:0]  neg_b_reg;
    logic [3:0]  cnz_reg;
    logic [3:0][3:0] cmsb_reg;
    wide3_t      mag_c_reg;
    logic [2:0]  neg_c_reg;
    logic [5:0]  msb_reg;
    logic        nz_c_reg;
    norm_side_t  side_d_reg;
    norm_side_t  side_e_reg;
    logic [2:0][59:0] sq_reg;
    norm_side_t  side_f_reg;
    logic [61:0] sum_reg;
    logic [30:0] n_g_reg;
    sign_side_t  sgn_g_reg;
    div_state_t  div_g_reg;
    vec3_t       o_reg;
    logic        nz_reg;

    logic [63:0] orw;
    logic [3:0]  cnz_next;
    logic [3:0][3:0] cmsb_next;
    logic [5:0]  msb_next;
    norm_side_t  side_d_next;
    logic [2:0][59:0] sq_next;
    logic [60:0] dvd;
    div_state_t  div_g_next;
    vec3_t       o_next;

    sqrt_state_t sq_st   [SQRT_STEPS+1];
    norm_side_t  sq_side [SQRT_STEPS+1];
    logic [30:0] dv_n    [DIV_STEPS+1];
    sign_side_t  dv_side [DIV_STEPS+1];
    div_state_t  dv_st   [DIV_STEPS+1];

    // leading one of the or of magnitudes, found per 16-bit chunk first
    always_comb
    begin
        orw = mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2];
        for (int c = 0; c < 4; c++)
        begin
            cnz_next[c]  = |orw[c*16 +: 16];
            cmsb_next[c] = '0;
            for (int b = 0; b < 16; b++)
            begin
                if (orw[c*16 + b])
                begin
                    cmsb_next[c] = 4'(b);
                end
            end
        end
        msb_next = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (cnz_reg[c])
            begin
                msb_next = {2'(c), cmsb_reg[c]};
            end
        end
        side_d_next.neg = neg_c_reg;
        side_d_next.nz  = nz_c_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (msb_reg >= 6'd29)
            begin
                side_d_next.mag[i] = 30'(mag_c_reg[i] >> (msb_reg - 6'd29));
            end
            else
            begin
                side_d_next.mag[i] = 30'(mag_c_reg[i] << (6'd29 - msb_reg));
            end
            sq_next[i] = side_d_reg.mag[i] * side_d_reg.mag[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_a_reg[i] <= v[i][63] ? (64'd0 - v[i]) : v[i];
                neg_a_reg[i] <= v[i][63];
            end
            mag_b_reg  <= mag_a_reg;
            neg_b_reg  <= neg_a_reg;
            cnz_reg    <= cnz_next;
            cmsb_reg   <= cmsb_next;
            mag_c_reg  <= mag_b_reg;
            neg_c_reg  <= neg_b_reg;
            msb_reg    <= msb_next;
            nz_c_reg   <= |cnz_reg;
            side_d_reg <= side_d_next;
            side_e_reg <= side_d_reg;
            sq_reg     <= sq_next;
            side_f_reg <= side_e_reg;
            sum_reg    <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
        end
    end

    assign sq_st[0].num   = 64'(sum_reg);
    assign sq_st[0].res   = '0;
    assign sq_st[0].probe = 64'd1 << 62;
    assign sq_side[0]     = side_f_reg;

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        cbfa_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .st_in    (sq_st[g]),
            .side_in  (sq_side[g]),
            .st_out   (sq_st[g+1]),
            .side_out (sq_side[g+1])
        );
    end

    // dividend is mag * 2^30 plus half the root for rounding
    always_comb
    begin
        div_g_next = '0;
        dvd        = '0;
        for (int i = 0; i < 3; i++)
        begin
            dvd = {1'b0, sq_side[SQRT_STEPS].mag[i], 30'd0}
                + 61'(sq_st[SQRT_STEPS].res[30:1]);
            div_g_next.rem[i] = {1'b0, dvd[60:31]};
            div_g_next.low[i] = dvd[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_g_reg       <= sq_st[SQRT_STEPS].res[30:0];
            sgn_g_reg.neg <= sq_side[SQRT_STEPS].neg;
            sgn_g_reg.nz  <= sq_side[SQRT_STEPS].nz;
            div_g_reg     <= div_g_next;
        end
    end

    assign dv_n[0]    = n_g_reg;
    assign dv_side[0] = sgn_g_reg;
    assign dv_st[0]   = div_g_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        cbfa_div_cell u_cell (
            .clk      (clk),
            .en       (en),
            .n_in     (dv_n[g]),
            .side_in  (dv_side[g]),
            .st_in    (dv_st[g]),
            .n_out    (dv_n[g+1]),
            .side_out (dv_side[g+1]),
            .st_out   (dv_st[g+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!dv_side[DIV_STEPS].nz)
            begin
                o_next[i] = '0;
            end
            else if (dv_side[DIV_STEPS].neg[i])
            begin
                o_next[i] = 32'd0 - {1'b0, dv_st[DIV_STEPS].quo[i]};
            end
            else
            begin
                o_next[i] = {1'b0, dv_st[DIV_STEPS].quo[i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg  <= o_next;
            nz_reg <= dv_side[DIV_STEPS].nz;
        end
    end

    assign o  = o_reg;
    assign nz = nz_reg;

endmodule
`default_nettype wire

@@ hw/rtl/camera_basis_from_angles.sv @@
`default_nettype none
// Euler-angle camera basis. Each beat on the slave side carries a yaw and a
// pitch binary angle; the block returns the unit front vector, right =
// normalize(front x world_up) and up = normalize(right x front) in Q1.14,
// plus a degenerate flag (right and up zero) when front is parallel to the
// world up vector or world up is zero. World up comes from three registers
// on the cfg port, reset to (0, 1.0, 0), to be written while no beat is in
// flight. The datapath is fully pipelined: one beat per clock unless the output
// beat waits while the last stage is full. It holds horner chains for sine and
// cosine, and a 32-step square root chain and a 31-step divider chain in each of
// the two normalizers. Idle stages are squeezed out while the output beat
// waits, so input is still taken until the last stage holds a result.
`include "camera_basis_from_angles_defines.svh"
module camera_basis_from_angles
    import cbfa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // yaw_angle, pitch_angle
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,   // front_x/y/z, right_x/y/z, up_x/y/z
    output logic              m_tuser,   // degenerate
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    logic [15:0] up_x_reg;
    logic [15:0] up_y_reg;
    logic [15:0] up_z_reg;

    logic [PIPE_LAT-1:0] vld_reg;
    logic                m_valid_reg;
    logic [143:0]        out_data_reg;
    logic                out_user_reg;
    logic                en;

    logic [31:0] ty;
    logic [31:0] tp;
    logic signed [31:0] pitch_s;
    logic signed [31:0] pitch_c;
    logic [31:0] sy, cy, sp, cp;

    logic signed [63:0] fp0_reg;
    logic signed [63:0] fp2_reg;
    logic [31:0]        sp_d_reg;
    vec3_t              f_reg;
    logic signed [47:0] cx_reg [6];
    wide3_t             r_reg;
    vec3_t              r30;
    logic               nz1;
    vec3_t [DLY-1:0]    f_dly1_reg;
    vec3_t              f_mid;
    logic signed [63:0] wx_reg [6];
    wide3_t             w_reg;
    vec3_t              up30;
    logic               nz2;
    vec3_t [DLY-1:0]    f_dly2_reg;
    vec3_t [DLY-1:0]    r_dly_reg;
    logic [DLY-1:0]     nz_dly_reg;

    logic               deg;
    logic [143:0]       out_data_next;
    logic signed [63:0] rs [3];
    logic signed [63:0] ws [3];

    assign en        = !m_valid_reg || m_tready || !vld_reg[PIPE_LAT-1];
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= '0;
            up_y_reg <= 16'(1 << FRAC_BITS);
            up_z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_UP_X: up_x_reg <= cfg_data;
                REG_UP_Y: up_y_reg <= cfg_data;
                REG_UP_Z: up_z_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // angles to 2^-32 turn, pitch clamped to a quarter turn
    always_comb
    begin
        ty      = (32'(s_tdata[15:0]) & AMASK) << (32 - ANGLE_BITS);
        pitch_s = signed'((32'(s_tdata[31:16]) & AMASK) << (32 - ANGLE_BITS))
                  >>> (32 - ANGLE_BITS);
        if (pitch_s > 32'sd0 + QUARTER)
        begin
            pitch_c = QUARTER;
        end
        else if (pitch_s < 32'sd0 - QUARTER)
        begin
            pitch_c = -QUARTER;
        end
        else
        begin
            pitch_c = pitch_s;
        end
        tp = 32'(pitch_c) << (32 - ANGLE_BITS);
    end

    cbfa_trig u_trig_yaw (
        .clk   (clk),
        .en    (en),
        .angle (ty),
        .sn    (sy),
        .cs    (cy)
    );

    cbfa_trig u_trig_pitch (
        .clk   (clk),
        .en    (en),
        .angle (tp),
        .sn    (sp),
        .cs    (cp)
    );

    always_comb
    begin
        rs[0] = 64'(cx_reg[0]) - 64'(cx_reg[1]);
        rs[1] = 64'(cx_reg[2]) - 64'(cx_reg[3]);
        rs[2] = 64'(cx_reg[4]) - 64'(cx_reg[5]);
        ws[0] = wx_reg[0] - wx_reg[1];
        ws[1] = wx_reg[2] - wx_reg[3];
        ws[2] = wx_reg[4] - wx_reg[5];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fp0_reg   <= signed'(cy) * signed'(cp);
            fp2_reg   <= signed'(sy) * signed'(cp);
            sp_d_reg  <= sp;
            f_reg[0]  <= round_q30(fp0_reg);
            f_reg[1]  <= sp_d_reg;
            f_reg[2]  <= round_q30(fp2_reg);
            cx_reg[0] <= signed'(f_reg[1]) * signed'(up_z_reg);
            cx_reg[1] <= signed'(f_reg[2]) * signed'(up_y_reg);
            cx_reg[2] <= signed'(f_reg[2]) * signed'(up_x_reg);
            cx_reg[3] <= signed'(f_reg[0]) * signed'(up_z_reg);
            cx_reg[4] <= signed'(f_reg[0]) * signed'(up_y_reg);
            cx_reg[5] <= signed'(f_reg[1]) * signed'(up_x_reg);
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= rs[i];
                w_reg[i] <= ws[i];
            end
            f_dly1_reg <= {f_dly1_reg[DLY-2:0], f_reg};
            wx_reg[0]  <= signed'(r30[1]) * signed'(f_mid[2]);
            wx_reg[1]  <= signed'(r30[2]) * signed'(f_mid[1]);
            wx_reg[2]  <= signed'(r30[2]) * signed'(f_mid[0]);
            wx_reg[3]  <= signed'(r30[0]) * signed'(f_mid[2]);
            wx_reg[4]  <= signed'(r30[0]) * signed'(f_mid[1]);
            wx_reg[5]  <= signed'(r30[1]) * signed'(f_mid[0]);
            f_dly2_reg <= {f_dly2_reg[DLY-2:0], f_mid};
            r_dly_reg  <= {r_dly_reg[DLY-2:0], r30};
            nz_dly_reg <= {nz_dly_reg[DLY-2:0], nz1};
        end
    end

    assign f_mid = f_dly1_reg[DLY-1];

    cbfa_norm u_norm_right (
        .clk (clk),
        .en  (en),
        .v   (r_reg),
        .o   (r30),
        .nz  (nz1)
    );

    cbfa_norm u_norm_up (
        .clk (clk),
        .en  (en),
        .v   (w_reg),
        .o   (up30),
        .nz  (nz2)
    );

    always_comb
    begin
        deg = !(nz_dly_reg[DLY-1] && nz2);
        for (int i = 0; i < 3; i++)
        begin
            out_data_next[i*16 +: 16]       = emit_q(f_dly2_reg[DLY-1][i]);
            out_data_next[(3+i)*16 +: 16]   = deg ? 16'd0 : emit_q(r_dly_reg[DLY-1][i]);
            out_data_next[(6+i)*16 +: 16]   = deg ? 16'd0 : emit_q(up30[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
            end
            if (!m_valid_reg || m_tready)
            begin
                m_valid_reg <= vld_reg[PIPE_LAT-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!m_valid_reg || m_tready)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= deg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `CBFA_ASSERT_SAME(a_deg_clears, m_tvalid && m_tuser, m_tdata[143:48] == '0)
    `CBFA_ASSERT_NEXT(a_beat_enters, s_tvalid && s_tready, vld_reg[0])
    `CBFA_ASSERT_SAME(a_full_stalls, m_tvalid && !m_tready && vld_reg[PIPE_LAT-1], !s_tready)

endmodule
`default_nettype wire
